FILE: rtl/oid_arc_pkg.sv
// Shared types and constants for the OBJECT IDENTIFIER arc decoder.
// Used by oid_arc_step, oid_arc_decoder and oid_arc_checker; no dependencies.
package oid_arc_pkg;

    localparam int unsigned ARC_OUT_BITS = 32;
    localparam int unsigned GROUP_BITS   = 7;
    localparam int unsigned CONT_BIT     = 7;          // continuation flag position
    localparam logic [7:0]  FIRST_DIV    = 8'd40;
    localparam logic [7:0]  FIRST_DIV2   = 8'd80;

    typedef struct packed {
        logic [7:0] content_byte;
        logic       first_octet;
        logic       final_octet;
    } in_t;

    typedef struct packed {
        logic [ARC_OUT_BITS-1:0] arc_value;
        logic                    last_arc;
        logic                    arc_overflow;
        logic                    arc_truncated;
    } out_t;

    // Which of the two possible results one octet produces.
    typedef struct packed {
        logic emit0;
        logic emit1;
    } step_ctl_t;

endpackage

FILE: rtl/oid_arc_step.sv
// Combinational decode of one content octet against the current arc state.
// Depends on oid_arc_pkg.
module oid_arc_step #(
    parameter int unsigned ARC_BITS = 32
) (
    input  oid_arc_pkg::in_t       in_data,
    input  logic [ARC_BITS-1:0]    acc,
    input  logic                   ovf,
    output oid_arc_pkg::step_ctl_t ctl,
    output oid_arc_pkg::out_t      res0,
    output oid_arc_pkg::out_t      res1,
    output logic [ARC_BITS-1:0]    acc_next,
    output logic                   ovf_next
);

    logic [ARC_BITS-1:0]                 acc_sh;
    logic                                ovf_sh;
    logic [oid_arc_pkg::ARC_OUT_BITS-1:0] arc_wide;
    logic [7:0]                          top_arc;
    logic [7:0]                          second_arc;

    assign acc_sh = {acc[ARC_BITS-oid_arc_pkg::GROUP_BITS-1:0],
                     in_data.content_byte[oid_arc_pkg::GROUP_BITS-1:0]};
    assign ovf_sh = ovf | (|acc[ARC_BITS-1 -: oid_arc_pkg::GROUP_BITS]);

    generate
        if (ARC_BITS >= oid_arc_pkg::ARC_OUT_BITS) begin : g_wide
            assign arc_wide = acc_sh[oid_arc_pkg::ARC_OUT_BITS-1:0];
        end else begin : g_narrow
            assign arc_wide = {{(oid_arc_pkg::ARC_OUT_BITS-ARC_BITS){1'b0}}, acc_sh};
        end
    endgenerate

    // First octet splits into two arcs per X.690.
    always_comb begin
        if (in_data.content_byte < oid_arc_pkg::FIRST_DIV) begin
            top_arc    = 8'd0;
            second_arc = in_data.content_byte;
        end else if (in_data.content_byte < oid_arc_pkg::FIRST_DIV2) begin
            top_arc    = 8'd1;
            second_arc = in_data.content_byte - oid_arc_pkg::FIRST_DIV;
        end else begin
            top_arc    = 8'd2;
            second_arc = in_data.content_byte - oid_arc_pkg::FIRST_DIV2;
        end
    end

    always_comb begin
        ctl      = '0;
        res0     = '0;
        res1     = '0;
        acc_next = '0;
        ovf_next = 1'b0;
        if (in_data.first_octet) begin
            ctl.emit0          = 1'b1;
            ctl.emit1          = 1'b1;
            res0.arc_value     = oid_arc_pkg::ARC_OUT_BITS'(top_arc);
            res1.arc_value     = oid_arc_pkg::ARC_OUT_BITS'(second_arc);
            res1.last_arc      = in_data.final_octet;
        end else if (!in_data.content_byte[oid_arc_pkg::CONT_BIT]) begin
            ctl.emit0          = 1'b1;
            res0.arc_value     = arc_wide;
            res0.last_arc      = in_data.final_octet;
            res0.arc_overflow  = ovf_sh;
        end else if (in_data.final_octet) begin
            ctl.emit0          = 1'b1;
            res0.arc_value     = arc_wide;
            res0.last_arc      = 1'b1;
            res0.arc_overflow  = ovf_sh;
            res0.arc_truncated = 1'b1;
        end else begin
            acc_next = acc_sh;
            ovf_next = ovf_sh;
        end
    end

endmodule

FILE: rtl/oid_arc_decoder.sv
// Top level of the OBJECT IDENTIFIER arc decoder.
// Depends on oid_arc_pkg and oid_arc_step.
//
// Feed the content octets of a BER/DER OBJECT IDENTIFIER, one per transaction,
// on s_data, marking the first octet of each identifier with first_octet and
// the last with final_octet. Each decoded arc leaves as one transaction on
// m_data. The first octet yields two arcs (0, 1 or 2, then the remainder);
// later octets gather base-128 groups into an ARC_BITS accumulator and give an
// arc when an octet with a clear top bit arrives. Arcs wider than ARC_BITS
// keep their low bits and raise arc_overflow; an identifier ending inside an
// arc gives the partial arc with arc_truncated and last_arc set. An octet that
// produces zero or one arc retires once the result register can take any arc it
// gives, so a stream of them flows at one transaction per clock while m_ready is
// high; a first octet places its two arcs one after the other in the single output
// register. An accepted octet is first held in the input register; its first arc
// is then loaded into the result register, which drives m_valid, once it is free.
module oid_arc_decoder #(
    parameter int unsigned ARC_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  oid_arc_pkg::in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output oid_arc_pkg::out_t m_data
);

    // Input register.
    logic              in_valid_reg, in_valid_next;
    oid_arc_pkg::in_t  in_data_reg;

    // Arc state.
    logic [ARC_BITS-1:0] acc_reg, acc_next;
    logic                ovf_reg, ovf_next;

    // Set while the second arc of a first octet is still owed.
    logic phase_reg, phase_next;

    // Result register.
    logic              m_valid_reg, m_valid_next;
    oid_arc_pkg::out_t m_data_reg;

    oid_arc_pkg::step_ctl_t ctl;
    oid_arc_pkg::out_t      res0, res1;
    logic [ARC_BITS-1:0]    step_acc;
    logic                   step_ovf;
    logic                   out_free;
    logic                   load_out;
    logic                   consume;

    oid_arc_step #(
        .ARC_BITS (ARC_BITS)
    ) u_step (
        .in_data  (in_data_reg),
        .acc      (acc_reg),
        .ovf      (ovf_reg),
        .ctl      (ctl),
        .res0     (res0),
        .res1     (res1),
        .acc_next (step_acc),
        .ovf_next (step_ovf)
    );

    always_comb begin
        // The result register can take a new arc when empty or being drained.
        out_free = !m_valid_reg || m_ready;
        load_out = in_valid_reg && ctl.emit0 && out_free;
        // Retire the held octet once every arc it owes has been loaded.
        consume  = in_valid_reg &&
                   (!ctl.emit0 || (out_free && (!ctl.emit1 || phase_reg)));
        s_ready  = !in_valid_reg || consume;

        in_valid_next = s_ready ? s_valid : in_valid_reg;

        // Hold the arc state until the octet retires.
        acc_next = consume ? step_acc : acc_reg;
        ovf_next = consume ? step_ovf : ovf_reg;

        // Advance to the second arc after loading the first of a pair, and back after the second.
        phase_next = phase_reg;
        if (load_out && ctl.emit1) begin
            phase_next = !phase_reg;
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            phase_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            phase_reg    <= phase_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (load_out) begin
            m_data_reg <= phase_reg ? res1 : res0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/oid_arc_checker.sv
// Port-level checks for oid_arc_decoder, bound to every instance.
// Depends on oid_arc_pkg and oid_arc_decoder.
module oid_arc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input oid_arc_pkg::in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input oid_arc_pkg::out_t m_data
);

    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed or dropped while stalled");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.arc_truncated |-> m_data.last_arc)
        else $error("truncated arc not marked last");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind oid_arc_decoder oid_arc_checker u_oid_arc_checker (.*);
